>>> design/csb_pkg.sv
package csb_pkg;

	// bank size and ring depth
	localparam int NUM_SEMS    = 8;
	localparam int QUEUE_DEPTH = 16;

	// field widths
	localparam int CMD_W   = 2;
	localparam int SEM_W   = 3;
	localparam int TASK_W  = 4;
	localparam int INIT_W  = 7;
	localparam int COUNT_W = 8;
	localparam int ERR_W   = 2;

	// derived storage widths
	localparam int SEM_IDX_W = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
	localparam int PTR_W     = $clog2(QUEUE_DEPTH);
	localparam int MEM_DEPTH = NUM_SEMS * QUEUE_DEPTH;
	localparam int ADDR_W    = $clog2(MEM_DEPTH);

	// count limits
	localparam logic signed [COUNT_W-1:0] COUNT_MAX   = COUNT_W'(127);
	localparam logic signed [COUNT_W-1:0] COUNT_FLOOR = COUNT_W'(-QUEUE_DEPTH);

	typedef enum logic [CMD_W-1:0] {
		CMD_INIT = 2'd0,
		CMD_WAIT = 2'd1,
		CMD_POST = 2'd2
	} cmd_t;

	typedef enum logic [ERR_W-1:0] {
		ERR_NONE  = 2'd0,
		ERR_FULL  = 2'd1,
		ERR_MAX   = 2'd2
	} err_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_RESP = 1'b1
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic exec;      // apply the accepted word to the bank
		logic load_out;  // move the finished result into the output register
	} dp_cmd_t;

endpackage

>>> design/csb_ctrl.sv
module csb_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	output logic               out_valid,
	input  logic               out_stall,
	output csb_pkg::dp_cmd_t   dp_cmd
);

	csb_pkg::state_t state_q, state_d;
	logic            out_valid_q;
	logic            out_free;

	// output register can take a new result this cycle
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		state_d = state_q;
		case (state_q)
			csb_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = csb_pkg::ST_RESP;
				end
			end
			csb_pkg::ST_RESP: begin
				if (out_free) begin
					state_d = csb_pkg::ST_IDLE;
				end
			end
			default: state_d = csb_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall        = 1'b1;
		dp_cmd.exec     = 1'b0;
		dp_cmd.load_out = 1'b0;
		case (state_q)
			csb_pkg::ST_IDLE: begin
				in_stall    = 1'b0;
				dp_cmd.exec = in_valid;
			end
			csb_pkg::ST_RESP: begin
				dp_cmd.load_out = out_free;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= csb_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (dp_cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

>>> design/csb_datapath.sv
module csb_datapath (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  csb_pkg::dp_cmd_t                      dp_cmd,
	input  logic [csb_pkg::CMD_W-1:0]             cmd,
	input  logic [csb_pkg::SEM_W-1:0]             sem_id,
	input  logic [csb_pkg::TASK_W-1:0]            task_id,
	input  logic [csb_pkg::INIT_W-1:0]            start_count,
	output logic                                  blocked,
	output logic                                  woke_valid,
	output logic [csb_pkg::TASK_W-1:0]            woke_task,
	output logic signed [csb_pkg::COUNT_W-1:0]    count_after,
	output logic [csb_pkg::ERR_W-1:0]             error
);

	// per-semaphore state
	logic signed [csb_pkg::COUNT_W-1:0] count_q   [csb_pkg::NUM_SEMS];
	logic [csb_pkg::PTR_W-1:0]          enq_ptr_q [csb_pkg::NUM_SEMS];
	logic [csb_pkg::PTR_W-1:0]          deq_ptr_q [csb_pkg::NUM_SEMS];

	// waiter rings, one region of QUEUE_DEPTH entries per semaphore
	logic [csb_pkg::TASK_W-1:0] waiter_mem [csb_pkg::MEM_DEPTH];
	logic [csb_pkg::TASK_W-1:0] rd_data_q;

	logic                               in_range;
	logic [csb_pkg::SEM_IDX_W-1:0]      idx;
	logic signed [csb_pkg::COUNT_W-1:0] cnt_cur, cnt_new;
	logic [csb_pkg::PTR_W-1:0]          enq_cur, deq_cur, enq_new, deq_new;
	logic                               blk, wake;
	csb_pkg::err_t                      err;
	logic [csb_pkg::ADDR_W-1:0]         base, wr_addr, rd_addr;

	// first-stage result held until the ring read returns
	logic                               blk_s1, wake_s1;
	logic signed [csb_pkg::COUNT_W-1:0] cnt_s1;
	logic [csb_pkg::ERR_W-1:0]          err_s1;

	function automatic logic [csb_pkg::PTR_W-1:0] ptr_inc(input logic [csb_pkg::PTR_W-1:0] p);
		if (p == csb_pkg::PTR_W'(csb_pkg::QUEUE_DEPTH - 1)) begin
			return '0;
		end
		return p + csb_pkg::PTR_W'(1);
	endfunction

	assign in_range = (int'(sem_id) < csb_pkg::NUM_SEMS);
	assign idx      = csb_pkg::SEM_IDX_W'(sem_id);

	always_comb begin
		cnt_cur = count_q[idx];
		enq_cur = enq_ptr_q[idx];
		deq_cur = deq_ptr_q[idx];
		cnt_new = cnt_cur;
		enq_new = enq_cur;
		deq_new = deq_cur;
		blk     = 1'b0;
		wake    = 1'b0;
		err     = csb_pkg::ERR_NONE;
		case (cmd)
			csb_pkg::CMD_INIT: begin
				cnt_new = {1'b0, start_count};
				enq_new = '0;
				deq_new = '0;
			end
			csb_pkg::CMD_WAIT: begin
				if (cnt_cur <= csb_pkg::COUNT_FLOOR) begin
					err = csb_pkg::ERR_FULL;
				end else begin
					cnt_new = cnt_cur - csb_pkg::COUNT_W'(1);
					if (cnt_new[csb_pkg::COUNT_W-1]) begin
						blk     = 1'b1;
						enq_new = ptr_inc(enq_cur);
					end
				end
			end
			csb_pkg::CMD_POST: begin
				if (cnt_cur >= csb_pkg::COUNT_MAX) begin
					err = csb_pkg::ERR_MAX;
				end else begin
					cnt_new = cnt_cur + csb_pkg::COUNT_W'(1);
					if (cnt_new[csb_pkg::COUNT_W-1] || cnt_new == '0) begin
						wake    = 1'b1;
						deq_new = ptr_inc(deq_cur);
					end
				end
			end
			default: ;
		endcase
	end

	assign base    = csb_pkg::ADDR_W'(idx) * csb_pkg::ADDR_W'(csb_pkg::QUEUE_DEPTH);
	assign wr_addr = base + csb_pkg::ADDR_W'(enq_cur);
	assign rd_addr = base + csb_pkg::ADDR_W'(deq_cur);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < csb_pkg::NUM_SEMS; i++) begin
				count_q[i]   <= '0;
				enq_ptr_q[i] <= '0;
				deq_ptr_q[i] <= '0;
			end
		end else if (dp_cmd.exec && in_range) begin
			count_q[idx]   <= cnt_new;
			enq_ptr_q[idx] <= enq_new;
			deq_ptr_q[idx] <= deq_new;
		end
	end

	always_ff @(posedge clk) begin
		if (dp_cmd.exec && in_range && blk) begin
			waiter_mem[wr_addr] <= task_id;
		end
		if (dp_cmd.exec) begin
			rd_data_q <= waiter_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (dp_cmd.exec) begin
			blk_s1  <= in_range && blk;
			wake_s1 <= in_range && wake;
			cnt_s1  <= in_range ? cnt_new : '0;
			err_s1  <= in_range ? err : csb_pkg::ERR_NONE;
		end
	end

	always_ff @(posedge clk) begin
		if (dp_cmd.load_out) begin
			blocked     <= blk_s1;
			woke_valid  <= wake_s1;
			woke_task   <= wake_s1 ? rd_data_q : '0;
			count_after <= cnt_s1;
			error       <= err_s1;
		end
	end

endmodule

>>> design/counting_semaphore_bank.sv
// counting semaphore bank with per-semaphore fifo rings of waiting task ids
// result path: a word's result passes the first-stage registers, then the output
//   register, and waits longer only while an earlier result still sits stalled there
// accept: a new word waits until the last result has moved to the output register;
//   count, pointers and ring read update on accept; the read is folded in on that move
// reset: arst_n clears all counts, ring pointers and handshake state at once;
//   ring entries are not cleared; a ring entry is only used after being written
module counting_semaphore_bank (
	input  logic                               clk,
	input  logic                               arst_n,
	// input channel
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [csb_pkg::CMD_W-1:0]          cmd,
	input  logic [csb_pkg::SEM_W-1:0]          sem_id,
	input  logic [csb_pkg::TASK_W-1:0]         task_id,
	input  logic [csb_pkg::INIT_W-1:0]         start_count,
	// output channel
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic                               blocked,
	output logic                               woke_valid,
	output logic [csb_pkg::TASK_W-1:0]         woke_task,
	output logic signed [csb_pkg::COUNT_W-1:0] count_after,
	output logic [csb_pkg::ERR_W-1:0]          error
);

	// command bundle from the sequencer to the datapath
	csb_pkg::dp_cmd_t dp_cmd;

	// two-state sequencer: idle takes a word, resp hands the result to the
	// output register as soon as that register is free; a stalled result in
	// the output register holds up the next accept
	csb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.dp_cmd    (dp_cmd)
	);

	// count and pointer registers, waiter ring memory, result registers
	// init: load count, rewind both pointers (ring contents stay)
	// wait: decrement; a negative count queues the caller at the enqueue pointer
	// post: increment; a count still at or below zero releases the head waiter
	// full ring on wait and maximum count on post report an error and change nothing
	csb_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.dp_cmd      (dp_cmd),
		.cmd         (cmd),
		.sem_id      (sem_id),
		.task_id     (task_id),
		.start_count (start_count),
		.blocked     (blocked),
		.woke_valid  (woke_valid),
		.woke_task   (woke_task),
		.count_after (count_after),
		.error       (error)
	);

endmodule

>>> design/csb_checker.sv
module csb_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	input  logic                               in_stall,
	input  logic                               out_valid,
	input  logic                               out_stall,
	input  logic                               blocked,
	input  logic                               woke_valid,
	input  logic [csb_pkg::TASK_W-1:0]         woke_task,
	input  logic signed [csb_pkg::COUNT_W-1:0] count_after,
	input  logic [csb_pkg::ERR_W-1:0]          error
);

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(blocked) && $stable(woke_valid)
			&& $stable(woke_task) && $stable(count_after) && $stable(error))
		else $error("stalled result word changed");

	// one word in flight: the block is busy right after an accept
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("accepted a word while busy");

	// an error changes nothing, so it never blocks or wakes
	a_err_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (error != csb_pkg::ERR_NONE) |-> !blocked && !woke_valid)
		else $error("error with blocked or woke set");

	// a queued caller leaves a negative count
	a_blk_neg: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && blocked |-> count_after[csb_pkg::COUNT_W-1] && !woke_valid)
		else $error("blocked with non-negative count");

	// a released waiter leaves a count at or below zero
	a_wake_le0: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && woke_valid |-> count_after[csb_pkg::COUNT_W-1] || count_after == '0)
		else $error("woke with positive count");

endmodule

bind counting_semaphore_bank csb_checker u_csb_checker (.*);
